[sv/vad_pkg.sv]
// ============================================================================
// vad_pkg: shared constants and elaboration functions
// Field widths, amplitude limits, scaling constants and the constant
// functions that build the log2 grid for the amplitude-to-DAC-code core.
// ============================================================================
`default_nettype none

package vad_pkg;

    // Default values of the top-level parameters.
    localparam int LOG_TABLE_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF      = 16;

    // Mantissa fraction width used by the log2 approximation.
    localparam int MANT_BITS = 30;

    // Field widths.
    localparam int OP_W   = 2;
    localparam int VAL_W  = 14;
    localparam int TGT_W  = 13;
    localparam int CODE_W = 12;
    localparam int REF_W  = 12;
    localparam int E_W    = 4;

    // Target amplitude limits in millivolts.
    localparam logic [TGT_W-1:0] TGT_MIN    = 13'd20;
    localparam logic [TGT_W-1:0] TGT_MAX    = 13'd7000;
    localparam logic [TGT_W-1:0] TGT_STEP   = 13'd200;
    localparam logic [TGT_W-1:0] TGT_RESET  = 13'd2000;
    localparam logic [VAL_W-1:0] UP_LIMIT   = 14'd7050;
    localparam logic [VAL_W-1:0] DOWN_SLACK = 14'd30;

    localparam logic [REF_W-1:0]  REF_RESET = 12'd3300;
    localparam logic [CODE_W-1:0] CODE_MAX  = 12'd4095;

    // 20*log10(2) in Q16.
    localparam int               K_W    = 19;
    localparam int               K_FRAC = 16;
    localparam logic [K_W-1:0]   K_Q16  = 19'd394566;

    // Control voltage slope: 1/0.0402 = 5000/201.
    localparam logic [12:0]      VDA_GAIN = 13'd5000;
    localparam logic [REF_W-1:0] VDA_DIV  = 12'd201;
    localparam int               VDA_MIN_MV = 126;
    localparam int               VDA_MAX_MV = 2121;

    // Widths of the two numerators scaled by the reference.
    localparam int SCALE_NUM_W  = 24;
    localparam int DIRECT_NUM_W = 26;

    // Grid point log2(1 + i/2^tb) in Q(fb), truncated, by repeated squaring.
    function automatic longint unsigned grid_log(input longint unsigned i,
                                                 input int tb, input int fb);
        longint unsigned m;
        longint unsigned r;
        if (i >= (64'd1 << tb))
            return 64'd1 << fb;
        m = (64'd1 << MANT_BITS) + (i << (MANT_BITS - tb));
        r = 64'd0;
        for (int k = 0; k < fb; k++)
        begin
            m = (m * m) >> MANT_BITS;
            r = r << 1;
            if (m >= (64'd2 << MANT_BITS))
            begin
                m = m >> 1;
                r = r | 64'd1;
            end
        end
        return r;
    endfunction

    // Interpolated log2 of a constant, the same way the datapath does it.
    function automatic longint unsigned log2_const(input longint unsigned x,
                                                   input int tb, input int fb);
        longint unsigned e;
        longint unsigned f;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned a;
        longint unsigned b;
        e = 64'd0;
        while (e < 64'd31 && (x >> (e + 64'd1)) != 64'd0)
            e = e + 64'd1;
        f   = (x << (MANT_BITS - e)) - (64'd1 << MANT_BITS);
        idx = f >> (MANT_BITS - tb);
        rem = f & ((64'd1 << (MANT_BITS - tb)) - 64'd1);
        a   = grid_log(idx, tb, fb);
        b   = grid_log(idx + 64'd1, tb, fb);
        return (e << fb) + a + (((b - a) * rem) >> (MANT_BITS - tb));
    endfunction

    // Constant part of the control voltage numerator:
    // round(64.539 * 2^fb) + 20*log10(107) in Q(fb).
    function automatic longint unsigned pos_const(input int tb, input int fb);
        longint unsigned c64;
        c64 = ((64'd64539 << fb) + 64'd500) / 64'd1000;
        return c64 + ((64'(K_Q16) * log2_const(64'd107, tb, fb)) >> K_FRAC);
    endfunction

endpackage

`default_nettype wire

[sv/vad_mul.sv]
// ============================================================================
// vad_mul: radix-4 serial multiplier
// Shift-and-add multiplier that retires two multiplier bits per cycle and
// stops as soon as the remaining multiplier bits are all zero.
// ============================================================================
`default_nettype none

module vad_mul #(
    parameter int AW = 23,
    parameter int BW = 22
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [AW-1:0]    mcand,
    input  wire logic [BW-1:0]    mplier,
    output logic                  done,
    output logic [AW+BW-1:0]      prod
);

    localparam int PW = AW + BW;

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] sh_reg, sh_next;
    logic [BW-1:0] b_reg, b_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] pp;

    // Partial product for the current two-bit digit.
    assign pp = (b_reg[0] ? sh_reg : '0) + (b_reg[1] ? {sh_reg[PW-2:0], 1'b0} : '0);

    always_comb
    begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            sh_next   = PW'(mcand);
            b_next    = mplier;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + pp;
            sh_next  = sh_reg << 2;
            b_next   = b_reg >> 2;
            if ((b_reg >> 2) == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            sh_reg   <= '0;
            b_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            sh_reg   <= sh_next;
            b_reg    <= b_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

[sv/vad_div.sv]
// ============================================================================
// vad_div: bit-serial restoring divider
// Produces one quotient bit per cycle from a left-aligned dividend; the
// number of quotient bits is chosen per operation.
// ============================================================================
`default_nettype none

module vad_div #(
    parameter int DW = 36,
    parameter int VW = 12
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DW-1:0]            dividend,
    input  wire logic [$clog2(DW+1)-1:0]  nbits,
    input  wire logic [VW-1:0]            divisor,
    output logic                          done,
    output logic [DW-1:0]                 quotient
);

    localparam int NBW = $clog2(DW + 1);

    logic [DW-1:0]  num_reg, num_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [VW-1:0]  rem_reg, rem_next;
    logic [VW-1:0]  den_reg, den_next;
    logic [NBW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [VW:0]    trial;
    logic [VW:0]    diff;
    logic           fits;

    assign trial = {rem_reg, num_reg[DW-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        num_next  = num_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next  = dividend;
            quo_next  = '0;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = nbits;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            cnt_next = cnt_reg - NBW'(1);
            if (cnt_reg == NBW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            quo_reg  <= '0;
            rem_reg  <= '0;
            den_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            num_reg  <= num_next;
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[sv/vga_amplitude_to_dac_code_core.sv]
// ============================================================================
// vga_amplitude_to_dac_code_core: output amplitude to gain DAC code
// Keeps the target output amplitude and turns it into the control code of
// the variable-gain stage through a fixed-point log and a serial datapath.
// ============================================================================
// The core holds a target amplitude in mV (2000 after reset). Each input item
// carries an op in s_tuser and a value in s_tdata: set the target (clamped to
// 20..7000), step it up or down by 200 mV, or write a direct voltage to the
// DAC without touching the target. For target ops the core forms
// gain = 20*log10(target/107) with an interpolated log2 table, the control
// voltage (64.539 - gain)/0.0402 mV clamped to 126..2121, and the code
// floor(vda*4095/ref), saturated to 4095; ref is the one configuration
// register; the user must write it over the cfg channel only while the core
// is idle, which the core does not enforce. Every item gives exactly one
// result item: the code, a flag that is 0 when a step was refused (then the
// previous code repeats), and the target after the item. Items are handled
// one at a time. A target op runs a normalize step, two table reads, three
// passes through a radix-4 serial multiplier and two passes through a
// bit-serial divider, which produces one quotient bit per cycle over
// FRAC_BITS + 20 and then 24 bits. A direct write runs one divider pass over
// 26 bits; a refused step goes straight to the result. The output register
// lets the next item be taken while a result still waits.
// ============================================================================
`default_nettype none

module vga_amplitude_to_dac_code_core #(
    parameter int LOG_TABLE_BITS = vad_pkg::LOG_TABLE_BITS_DEF,
    parameter int FRAC_BITS      = vad_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Configuration write: dac_reference_mv.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [11:0] cfg_data,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [13:0] value_mv, [15:14] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] op

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [11:0] dac_code, [24:12] target_now_mv
    output logic [0:0]       m_tuser    // [0] dac_written
);

    // ------------------------------------------------------------------
    // Derived widths
    // ------------------------------------------------------------------
    localparam int TB     = LOG_TABLE_BITS;
    localparam int FB     = FRAC_BITS;
    localparam int RW     = vad_pkg::MANT_BITS - TB;       // interpolation remainder
    localparam int GW     = FB + 1;                        // grid value
    localparam int GRID_N = (2 ** TB) + 1;
    localparam int LW     = FB + 4;                        // log2 of the target
    localparam int DDW    = FB + 7;                        // dB difference
    localparam int MCW    = FB + 7;                        // multiplicand
    localparam int MPW    = (RW > vad_pkg::K_W) ? RW : vad_pkg::K_W;
    localparam int PW     = MCW + MPW;
    localparam int DW     = FB + 20;                       // dividend
    localparam int VW     = FB + 12;                       // control voltage
    localparam int NBW    = $clog2(DW + 1);
    localparam int FPAD   = vad_pkg::MANT_BITS - (vad_pkg::TGT_W - 1);

    localparam logic [DDW-1:0] POS_Q  = DDW'(vad_pkg::pos_const(TB, FB));
    localparam logic [VW-1:0]  VDA_LO = VW'(vad_pkg::VDA_MIN_MV) << FB;
    localparam logic [VW-1:0]  VDA_HI = VW'(vad_pkg::VDA_MAX_MV) << FB;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_UP     = 2'd1,
        OP_DOWN   = 2'd2,
        OP_DIRECT = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_LOOKA,
        S_LOOKB,
        S_MULI,
        S_MULK,
        S_MULD,
        S_DIV201,
        S_SCALE,
        S_DIVREF,
        S_DONE
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                          state_reg, state_next;
    logic [vad_pkg::TGT_W-1:0]       target_reg, target_next;
    logic [vad_pkg::CODE_W-1:0]      last_code_reg, last_code_next;
    logic [vad_pkg::REF_W-1:0]       ref_reg, ref_next;
    logic                            written_reg, written_next;
    logic [vad_pkg::E_W-1:0]         e_reg, e_next;
    logic [TB-1:0]                   idx_reg, idx_next;
    logic [RW-1:0]                   rem_reg, rem_next;
    logic [GW-1:0]                   a_reg, a_next;
    logic [VW-1:0]                   vda_reg, vda_next;
    logic                            mul_start_reg, mul_start_next;
    logic [MCW-1:0]                  mul_a_reg, mul_a_next;
    logic [MPW-1:0]                  mul_b_reg, mul_b_next;
    logic                            div_start_reg, div_start_next;
    logic [DW-1:0]                   div_num_reg, div_num_next;
    logic [vad_pkg::REF_W-1:0]       div_den_reg, div_den_next;
    logic [NBW-1:0]                  div_bits_reg, div_bits_next;
    logic                            out_valid_reg, out_valid_next;
    logic [vad_pkg::CODE_W-1:0]      out_code_reg, out_code_next;
    logic                            out_written_reg, out_written_next;
    logic [vad_pkg::TGT_W-1:0]       out_target_reg, out_target_next;

    // ------------------------------------------------------------------
    // Input decode and target update
    // ------------------------------------------------------------------
    op_t                             in_op;
    logic [vad_pkg::VAL_W-1:0]       in_val;
    logic [vad_pkg::TGT_W-1:0]       set_tgt;
    logic [vad_pkg::VAL_W-1:0]       up_sum;
    logic                            up_ok;
    logic [vad_pkg::TGT_W-1:0]       up_tgt;
    logic                            dn_ok;
    logic [vad_pkg::TGT_W-1:0]       dn_tgt;
    logic [vad_pkg::DIRECT_NUM_W-1:0] direct_num;

    assign in_op  = op_t'(s_tuser);
    assign in_val = s_tdata[vad_pkg::VAL_W-1:0];

    assign set_tgt = (in_val < vad_pkg::VAL_W'(vad_pkg::TGT_MIN)) ? vad_pkg::TGT_MIN :
                     (in_val > vad_pkg::VAL_W'(vad_pkg::TGT_MAX)) ? vad_pkg::TGT_MAX :
                     in_val[vad_pkg::TGT_W-1:0];

    // A step up is taken when target + 200 stays at or below 7050.
    assign up_sum = vad_pkg::VAL_W'(target_reg) + vad_pkg::VAL_W'(vad_pkg::TGT_STEP);
    assign up_ok  = up_sum <= vad_pkg::UP_LIMIT;
    assign up_tgt = (up_sum > vad_pkg::VAL_W'(vad_pkg::TGT_MAX)) ? vad_pkg::TGT_MAX :
                    up_sum[vad_pkg::TGT_W-1:0];

    // A step down is taken when target - 200 stays at or above -30.
    assign dn_ok  = (vad_pkg::VAL_W'(target_reg) + vad_pkg::DOWN_SLACK)
                    >= vad_pkg::VAL_W'(vad_pkg::TGT_STEP);
    assign dn_tgt = (target_reg < (vad_pkg::TGT_STEP + vad_pkg::TGT_MIN)) ? vad_pkg::TGT_MIN :
                    target_reg - vad_pkg::TGT_STEP;

    // value * 4095 as (value << 12) - value.
    assign direct_num = {in_val, 12'd0} - vad_pkg::DIRECT_NUM_W'(in_val);

    // ------------------------------------------------------------------
    // Normalization of the target: top-bit index and mantissa fraction
    // ------------------------------------------------------------------
    logic [vad_pkg::E_W-1:0]         e_c;
    logic [vad_pkg::TGT_W-1:0]       norm_c;
    logic [vad_pkg::MANT_BITS-1:0]   f_c;

    always_comb
    begin
        e_c = '0;
        for (int i = 0; i < vad_pkg::TGT_W; i++)
        begin
            if (target_reg[i])
                e_c = vad_pkg::E_W'(i);
        end
    end

    assign norm_c = target_reg << (vad_pkg::E_W'(vad_pkg::TGT_W - 1) - e_c);
    assign f_c    = {norm_c[vad_pkg::TGT_W-2:0], FPAD'(0)};

    // ------------------------------------------------------------------
    // log2 grid, read once per cycle: g(idx) then g(idx + 1)
    // ------------------------------------------------------------------
    logic [GW-1:0] grid_rom [GRID_N];
    logic [TB:0]   grid_sel;
    logic [GW-1:0] grid_val;

    for (genvar gi = 0; gi < GRID_N; gi++)
    begin : g_grid
        assign grid_rom[gi] = GW'(vad_pkg::grid_log(64'(gi), TB, FB));
    end

    assign grid_sel = (state_reg == S_LOOKB) ? ({1'b0, idx_reg} + (TB+1)'(1)) :
                                               {1'b0, idx_reg};
    assign grid_val = grid_rom[grid_sel];

    // ------------------------------------------------------------------
    // Serial arithmetic units
    // ------------------------------------------------------------------
    logic          mul_done;
    logic [PW-1:0] mul_prod;
    logic          div_done;
    logic [DW-1:0] div_quo;

    vad_mul #(
        .AW (MCW),
        .BW (MPW)
    ) u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .mcand  (mul_a_reg),
        .mplier (mul_b_reg),
        .done   (mul_done),
        .prod   (mul_prod)
    );

    vad_div #(
        .DW (DW),
        .VW (vad_pkg::REF_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_num_reg),
        .nbits    (div_bits_reg),
        .divisor  (div_den_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // Datapath between the passes
    // ------------------------------------------------------------------
    logic [GW-1:0]                  interp_c;
    logic [LW-1:0]                  log_c;
    logic [DDW-1:0]                 neg_c;
    logic [DDW-1:0]                 d_c;
    logic [VW-1:0]                  vda_c;
    logic [VW+11:0]                 scale_full;
    logic [vad_pkg::SCALE_NUM_W-1:0] scale_num;
    logic [vad_pkg::CODE_W-1:0]     code_sat;

    // Linear interpolation between grid points, then e + fraction.
    assign interp_c = mul_prod[RW +: GW];
    assign log_c    = {e_reg, FB'(0)} + LW'(a_reg) + LW'(interp_c);

    // gain in Q(FB); the difference to the constant is floored at zero.
    assign neg_c = mul_prod[vad_pkg::K_FRAC +: DDW];
    assign d_c   = (POS_Q > neg_c) ? (POS_Q - neg_c) : '0;

    assign vda_c = (div_quo < DW'(VDA_LO)) ? VDA_LO :
                   (div_quo > DW'(VDA_HI)) ? VDA_HI :
                   div_quo[VW-1:0];

    // floor(vda*4095 / (ref*2^FB)) equals floor(((vda*4095) >> FB) / ref).
    assign scale_full = {vda_reg, 12'd0} - (VW+12)'(vda_reg);
    assign scale_num  = scale_full[FB +: vad_pkg::SCALE_NUM_W];

    // A zero reference makes the divider return all ones, which saturates.
    assign code_sat = (div_quo > DW'(vad_pkg::CODE_MAX)) ? vad_pkg::CODE_MAX :
                      div_quo[vad_pkg::CODE_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        target_next      = target_reg;
        last_code_next   = last_code_reg;
        ref_next         = ref_reg;
        written_next     = written_reg;
        e_next           = e_reg;
        idx_next         = idx_reg;
        rem_next         = rem_reg;
        a_next           = a_reg;
        vda_next         = vda_reg;
        mul_start_next   = 1'b0;
        mul_a_next       = mul_a_reg;
        mul_b_next       = mul_b_reg;
        div_start_next   = 1'b0;
        div_num_next     = div_num_reg;
        div_den_next     = div_den_reg;
        div_bits_next    = div_bits_reg;
        out_valid_next   = out_valid_reg;
        out_code_next    = out_code_reg;
        out_written_next = out_written_reg;
        out_target_next  = out_target_reg;

        if (cfg_valid)
            ref_next = cfg_data;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    written_next = 1'b1;
                    case (in_op)
                        OP_SET:
                        begin
                            target_next = set_tgt;
                            state_next  = S_NORM;
                        end
                        OP_UP:
                        begin
                            if (up_ok)
                            begin
                                target_next = up_tgt;
                                state_next  = S_NORM;
                            end
                            else
                            begin
                                written_next = 1'b0;
                                state_next   = S_DONE;
                            end
                        end
                        OP_DOWN:
                        begin
                            if (dn_ok)
                            begin
                                target_next = dn_tgt;
                                state_next  = S_NORM;
                            end
                            else
                            begin
                                written_next = 1'b0;
                                state_next   = S_DONE;
                            end
                        end
                        OP_DIRECT:
                        begin
                            div_num_next   = {direct_num, (DW - vad_pkg::DIRECT_NUM_W)'(0)};
                            div_bits_next  = NBW'(vad_pkg::DIRECT_NUM_W);
                            div_den_next   = ref_reg;
                            div_start_next = 1'b1;
                            state_next     = S_DIVREF;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_NORM:
            begin
                e_next     = e_c;
                idx_next   = f_c[vad_pkg::MANT_BITS-1 -: TB];
                rem_next   = f_c[RW-1:0];
                state_next = S_LOOKA;
            end

            S_LOOKA:
            begin
                a_next     = grid_val;
                state_next = S_LOOKB;
            end

            S_LOOKB:
            begin
                mul_a_next     = MCW'(grid_val - a_reg);
                mul_b_next     = MPW'(rem_reg);
                mul_start_next = 1'b1;
                state_next     = S_MULI;
            end

            S_MULI:
            begin
                if (mul_done)
                begin
                    mul_a_next     = MCW'(log_c);
                    mul_b_next     = MPW'(vad_pkg::K_Q16);
                    mul_start_next = 1'b1;
                    state_next     = S_MULK;
                end
            end

            S_MULK:
            begin
                if (mul_done)
                begin
                    mul_a_next     = MCW'(d_c);
                    mul_b_next     = MPW'(vad_pkg::VDA_GAIN);
                    mul_start_next = 1'b1;
                    state_next     = S_MULD;
                end
            end

            S_MULD:
            begin
                if (mul_done)
                begin
                    div_num_next   = mul_prod[DW-1:0];
                    div_bits_next  = NBW'(DW);
                    div_den_next   = vad_pkg::VDA_DIV;
                    div_start_next = 1'b1;
                    state_next     = S_DIV201;
                end
            end

            S_DIV201:
            begin
                if (div_done)
                begin
                    vda_next   = vda_c;
                    state_next = S_SCALE;
                end
            end

            S_SCALE:
            begin
                div_num_next   = {scale_num, (DW - vad_pkg::SCALE_NUM_W)'(0)};
                div_bits_next  = NBW'(vad_pkg::SCALE_NUM_W);
                div_den_next   = ref_reg;
                div_start_next = 1'b1;
                state_next     = S_DIVREF;
            end

            S_DIVREF:
            begin
                if (div_done)
                begin
                    last_code_next = code_sat;
                    state_next     = S_DONE;
                end
            end

            S_DONE:
            begin
                // Hand the result to the output register once it is free.
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_code_next    = last_code_reg;
                    out_written_next = written_reg;
                    out_target_next  = target_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            target_reg      <= vad_pkg::TGT_RESET;
            last_code_reg   <= '0;
            ref_reg         <= vad_pkg::REF_RESET;
            written_reg     <= 1'b0;
            e_reg           <= '0;
            idx_reg         <= '0;
            rem_reg         <= '0;
            a_reg           <= '0;
            vda_reg         <= '0;
            mul_start_reg   <= 1'b0;
            mul_a_reg       <= '0;
            mul_b_reg       <= '0;
            div_start_reg   <= 1'b0;
            div_num_reg     <= '0;
            div_den_reg     <= '0;
            div_bits_reg    <= '0;
            out_valid_reg   <= 1'b0;
            out_code_reg    <= '0;
            out_written_reg <= 1'b0;
            out_target_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            target_reg      <= target_next;
            last_code_reg   <= last_code_next;
            ref_reg         <= ref_next;
            written_reg     <= written_next;
            e_reg           <= e_next;
            idx_reg         <= idx_next;
            rem_reg         <= rem_next;
            a_reg           <= a_next;
            vda_reg         <= vda_next;
            mul_start_reg   <= mul_start_next;
            mul_a_reg       <= mul_a_next;
            mul_b_reg       <= mul_b_next;
            div_start_reg   <= div_start_next;
            div_num_reg     <= div_num_next;
            div_den_reg     <= div_den_next;
            div_bits_reg    <= div_bits_next;
            out_valid_reg   <= out_valid_next;
            out_code_reg    <= out_code_next;
            out_written_reg <= out_written_next;
            out_target_reg  <= out_target_next;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_target_reg, out_code_reg};
    assign m_tuser   = out_written_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // The multiplier only finishes while the sequencer waits for it.
    a_mul_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MULI || state_reg == S_MULK || state_reg == S_MULD))
        else $error("multiplier finished outside a multiply pass");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV201 || state_reg == S_DIVREF))
        else $error("divider finished outside a divide pass");

    // The clamped control voltage stays within its limits when it is scaled.
    a_vda_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCALE) |-> (vda_reg >= VDA_LO && vda_reg <= VDA_HI))
        else $error("control voltage out of range");

    // An accepted item blocks the input until its result is produced.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in flight");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench for vga_amplitude_to_dac_code_core
// Drives amplitude commands and reference writes into the core and checks
// every result item against a typed value or a fixed-point gain law predictor.
// ============================================================================
// The run starts with a short table of directed items. The rows cover the
// clamps, the step limits, refused steps, a zero reference and a full-scale
// reference. A few rows carry their expected result typed in. All other rows,
// and the random phases that follow, are checked against the predictor
// below. Each random phase first waits until the core has delivered every
// pending result. It then writes a new DAC reference and sends a mix of set
// commands, runs of steps that push the target into both limits, and direct
// writes. Both stream sides idle in random bursts, except in quiet phases.
// ============================================================================

module tb_top;

    // Fixed-point layout of the log approximation, as built into the core.
    localparam int TABLE_BITS = vad_pkg::LOG_TABLE_BITS_DEF;
    localparam int FRAC       = vad_pkg::FRAC_BITS_DEF;
    localparam int MANT       = vad_pkg::MANT_BITS;

    // 20*log10(2) in Q16, the dB per octave of the log2 result.
    localparam longint unsigned DB_PER_OCTAVE_Q16 = 64'd394566;
    localparam longint unsigned INPUT_MV          = 64'd107;
    localparam longint unsigned CODE_FULL         = 64'd4095;

    // Target amplitude behavior in millivolts.
    localparam int LEVEL_MIN   = 20;
    localparam int LEVEL_MAX   = 7000;
    localparam int LEVEL_STEP  = 200;
    localparam int LEVEL_RESET = 2000;
    localparam int UP_CEILING  = 7050;
    localparam int DOWN_FLOOR  = -30;
    localparam int REF_RESET   = 3300;

    // Run control. The limit is several times the worst case for the roughly
    // 1575 items sent, counting the slowest item and the random gaps on each side.
    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 194;
    localparam int PRINT_CAP       = 100;

    typedef enum logic [1:0] {
        OP_SET    = 2'd0,
        OP_UP     = 2'd1,
        OP_DOWN   = 2'd2,
        OP_DIRECT = 2'd3
    } op_e;

    typedef enum logic {
        ROW_ITEM = 1'b0,
        ROW_CFG  = 1'b1
    } row_kind_e;

    typedef struct packed {
        logic [vad_pkg::CODE_W-1:0] code;
        logic                       written;
        logic [vad_pkg::TGT_W-1:0]  level;
    } dac_result_t;

    typedef struct {
        row_kind_e   kind;
        op_e         op;
        int          value;
        bit          fixed;
        dac_result_t known;
    } stim_row_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [11:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;

    // Predictor state: the stored target, the code the DAC holds and the
    // reference register.
    logic [vad_pkg::TGT_W-1:0]  level_mv = LEVEL_RESET;
    logic [vad_pkg::CODE_W-1:0] held_code = '0;
    logic [vad_pkg::REF_W-1:0]  ref_mv = REF_RESET;

    longint unsigned log_grid [0:(1 << TABLE_BITS)];
    dac_result_t     expected_dac [$];
    stim_row_t       directed_rows [$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  stall_left  = 0;
    bit  idle_enable = 1'b1;

    vga_amplitude_to_dac_code_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Grid point log2(1 + i/2^TABLE_BITS) in Q(FRAC). Squaring the mantissa
    // doubles its log, so each pass yields one more bit of the fraction.
    function automatic longint unsigned grid_point(input int i);
        longint unsigned mant;
        longint unsigned bits;
        if (i >= (1 << TABLE_BITS))
            return 64'd1 << FRAC;
        mant = (64'd1 << MANT) + (64'(i) << (MANT - TABLE_BITS));
        bits = 64'd0;
        repeat (FRAC)
        begin
            mant = (mant * mant) >> MANT;
            bits = bits << 1;
            if ((mant >> (MANT + 1)) != 64'd0)
            begin
                mant = mant >> 1;
                bits = bits | 64'd1;
            end
        end
        return bits;
    endfunction

    // log2 of a positive integer in Q(FRAC): the exponent plus a linear
    // interpolation between two grid points of the mantissa fraction.
    function automatic longint unsigned log2_fixed(input int unsigned x);
        int              top;
        longint unsigned frac;
        longint unsigned idx;
        longint unsigned rem;
        longint unsigned lo;
        longint unsigned hi;
        if (x == 0)
            x = 1;
        top  = $clog2(x + 1) - 1;
        frac = (64'(x) << (MANT - top)) - (64'd1 << MANT);
        idx  = frac >> (MANT - TABLE_BITS);
        rem  = frac & ((64'd1 << (MANT - TABLE_BITS)) - 64'd1);
        lo   = log_grid[idx];
        hi   = log_grid[idx + 1];
        return (64'(top) << FRAC) + lo + (((hi - lo) * rem) >> (MANT - TABLE_BITS));
    endfunction

    function automatic logic [11:0] scaled_code(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quot;
        if (den == 64'd0)
            return CODE_FULL[11:0];
        quot = num / den;
        return (quot > CODE_FULL) ? CODE_FULL[11:0] : quot[11:0];
    endfunction

    // Control voltage (64.539 - gain_dB) / 0.0402 in Q(FRAC), clamped to the
    // range of the gain stage, then scaled to a DAC code by the reference.
    function automatic logic [11:0] level_code(input int unsigned lvl,
                                               input longint unsigned refv);
        longint unsigned offset;
        longint unsigned pos;
        longint unsigned neg;
        longint unsigned diff;
        longint unsigned vda;
        offset = ((64'd64539 << FRAC) + 64'd500) / 64'd1000;
        pos    = offset + ((DB_PER_OCTAVE_Q16 * log2_fixed(INPUT_MV)) >> 16);
        neg    = (DB_PER_OCTAVE_Q16 * log2_fixed(lvl)) >> 16;
        diff   = (pos > neg) ? pos - neg : 64'd0;
        vda    = (diff * 64'd5000) / 64'd201;
        if (vda < (64'd126 << FRAC))
            vda = 64'd126 << FRAC;
        if (vda > (64'd2121 << FRAC))
            vda = 64'd2121 << FRAC;
        return scaled_code(vda * CODE_FULL, refv << FRAC);
    endfunction

    task automatic set_level(input int v);
        if (v < LEVEL_MIN)
            v = LEVEL_MIN;
        if (v > LEVEL_MAX)
            v = LEVEL_MAX;
        level_mv  = v[12:0];
        held_code = level_code(v, 64'(ref_mv));
    endtask

    // Advances the predictor by one accepted item and returns its result.
    task automatic predict_dac(input op_e op, input logic [13:0] val,
                               output dac_result_t res);
        int stepped;
        res.written = 1'b1;
        case (op)
            OP_SET:
                set_level(int'(val));
            OP_UP:
            begin
                stepped = int'(level_mv) + LEVEL_STEP;
                if (stepped <= UP_CEILING)
                    set_level(stepped);
                else
                    res.written = 1'b0;
            end
            OP_DOWN:
            begin
                stepped = int'(level_mv) - LEVEL_STEP;
                if (stepped >= DOWN_FLOOR)
                    set_level(stepped);
                else
                    res.written = 1'b0;
            end
            default:
                held_code = scaled_code(64'(val) * CODE_FULL, 64'(ref_mv));
        endcase
        res.code  = held_code;
        res.level = level_mv;
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_CAP)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_row(input row_kind_e kind, input op_e op, input int value,
                           input bit fixed, input int code, input bit written,
                           input int level);
        stim_row_t row;
        row.kind          = kind;
        row.op            = op;
        row.value         = value;
        row.fixed         = fixed;
        row.known.code    = code[11:0];
        row.known.written = written;
        row.known.level   = level[12:0];
        directed_rows.push_back(row);
    endtask

    // Random value: mostly inside the useful amplitude range, with extra
    // weight near both clamps, and sometimes anywhere in the 14-bit field.
    function automatic logic [13:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 16383);
            4:       return $urandom_range(0, 300);
            5:       return $urandom_range(6700, 7200);
            default: return $urandom_range(0, 7100);
        endcase
    endfunction

    // Sends one item. The valid stays high from one item to the next unless
    // a random gap is taken, so back-to-back items are also exercised.
    task automatic send_item(input op_e op, input logic [13:0] val,
                             input bit fixed, input dac_result_t known);
        dac_result_t predicted;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, val};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (!s_tready);
        predict_dac(op, val, predicted);
        expected_dac.push_back(fixed ? known : predicted);
    endtask

    task automatic wait_drained();
        while (expected_dac.size() != 0)
            @(posedge clk);
    endtask

    // The reference is only written once the core has handed over every
    // result, so that no item in flight sees the new divisor.
    task automatic write_reference(input logic [11:0] v);
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        ref_mv = v;
        cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure: random stall bursts while idling is enabled.
    always @(posedge clk)
    begin
        if (stall_left != 0)
            stall_left = stall_left - 1;
        else if (idle_enable && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 10);
        m_tready <= (stall_left == 0);
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        dac_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_dac.size() == 0)
                report_mismatch($sformatf("result with nothing expected: code %0d",
                                          m_tdata[11:0]));
            else
            begin
                want = expected_dac.pop_front();
                if (m_tdata[11:0] !== want.code)
                    report_mismatch($sformatf("dac_code got %0d want %0d",
                                              m_tdata[11:0], want.code));
                if (m_tuser[0] !== want.written)
                    report_mismatch($sformatf("dac_written got %0d want %0d",
                                              m_tuser[0], want.written));
                if (m_tdata[24:12] !== want.level)
                    report_mismatch($sformatf("target_now_mv got %0d want %0d",
                                              m_tdata[24:12], want.level));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        for (int i = 0; i <= (1 << TABLE_BITS); i++)
            log_grid[i] = grid_point(i);

        // Directed table. Typed results come right after reset, at the
        // saturation points and at a refused step after a known direct code.
        add_row(ROW_ITEM, OP_DIRECT, 0,     1, 0,    1, 2000);
        add_row(ROW_ITEM, OP_DIRECT, 16383, 1, 4095, 1, 2000);
        add_row(ROW_ITEM, OP_DIRECT, 1,     1, 1,    1, 2000);
        add_row(ROW_ITEM, OP_SET,    0,     0, 0, 0, 0);     // clamps up to 20
        add_row(ROW_ITEM, OP_DOWN,   0,     0, 0, 0, 0);     // refused at 20
        add_row(ROW_ITEM, OP_SET,    16383, 0, 0, 0, 0);     // clamps to 7000
        add_row(ROW_ITEM, OP_DIRECT, 0,     1, 0,    1, 7000);
        add_row(ROW_ITEM, OP_UP,     0,     1, 0,    0, 7000);
        add_row(ROW_ITEM, OP_SET,    6850,  0, 0, 0, 0);
        add_row(ROW_ITEM, OP_UP,     0,     0, 0, 0, 0);     // 7050 taken, clamped
        add_row(ROW_ITEM, OP_SET,    6851,  0, 0, 0, 0);
        add_row(ROW_ITEM, OP_UP,     0,     0, 0, 0, 0);     // 7051 refused
        add_row(ROW_ITEM, OP_SET,    170,   0, 0, 0, 0);
        add_row(ROW_ITEM, OP_DOWN,   0,     0, 0, 0, 0);     // -30 taken, clamped
        add_row(ROW_ITEM, OP_SET,    169,   0, 0, 0, 0);
        add_row(ROW_ITEM, OP_DOWN,   0,     0, 0, 0, 0);     // -31 refused
        add_row(ROW_ITEM, OP_SET,    107,   0, 0, 0, 0);     // unity gain
        add_row(ROW_ITEM, OP_SET,    7001,  0, 0, 0, 0);
        add_row(ROW_ITEM, OP_UP,     16383, 0, 0, 0, 0);     // value is ignored
        add_row(ROW_CFG,  OP_SET,    0,     0, 0, 0, 0);
        add_row(ROW_ITEM, OP_DIRECT, 0,     1, 4095, 1, 7000);
        add_row(ROW_ITEM, OP_SET,    2000,  1, 4095, 1, 2000);
        add_row(ROW_CFG,  OP_SET,    4095,  0, 0, 0, 0);
        add_row(ROW_ITEM, OP_DIRECT, 4094,  1, 4094, 1, 2000);
        add_row(ROW_ITEM, OP_DIRECT, 16383, 1, 4095, 1, 2000);
        add_row(ROW_ITEM, OP_DOWN,   0,     0, 0, 0, 0);
        add_row(ROW_CFG,  OP_SET,    REF_RESET, 0, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CFG)
                write_reference(directed_rows[i].value[11:0]);
            else
                send_item(directed_rows[i].op, directed_rows[i].value[13:0],
                          directed_rows[i].fixed, directed_rows[i].known);
        end

        // Random phases, each under its own reference. Phase 2 and the last
        // phase run without any idling on either side.
        for (int p = 0; p < PHASES; p++)
        begin
            logic [11:0] ref_pick;
            int          sent;
            int          run;
            op_e         dir;
            case (p)
                0:       ref_pick = 12'd1000;
                1:       ref_pick = 12'd3600;
                2:       ref_pick = $urandom_range(1000, 3600);
                3:       ref_pick = 12'd0;
                4:       ref_pick = 12'd4095;
                5:       ref_pick = $urandom_range(1, 999);
                6:       ref_pick = $urandom_range(0, 4095);
                default: ref_pick = REF_RESET;
            endcase
            idle_enable = (p != 2) && (p != PHASES - 1);
            write_reference(ref_pick);
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                case ($urandom_range(0, 9))
                    3, 4, 5:
                    begin
                        // A run of steps in one direction walks the target
                        // into a limit, where the steps start being refused.
                        run = $urandom_range(1, 40);
                        dir = ($urandom_range(0, 1) != 0) ? OP_UP : OP_DOWN;
                        for (int k = 0; k < run && sent < ITEMS_PER_PHASE; k++)
                        begin
                            send_item(dir, $urandom_range(0, 16383), 1'b0, '0);
                            sent++;
                        end
                    end
                    6:
                    begin
                        dir = ($urandom_range(0, 1) != 0) ? OP_UP : OP_DOWN;
                        send_item(dir, $urandom_range(0, 16383), 1'b0, '0);
                        sent++;
                    end
                    7, 8:
                    begin
                        send_item(OP_DIRECT, pick_value(), 1'b0, '0);
                        sent++;
                    end
                    default:
                    begin
                        send_item(OP_SET, pick_value(), 1'b0, '0);
                        sent++;
                    end
                endcase
            end
        end

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
